// ===== rtl/core/lrukv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_pkg
// Types and constants shared by the LRU key-value cache.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int RANK_W  = IDX_W;

  localparam int MODE_W  = 2;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CAP_W-1:0]          CAP_RESET    = CAP_W'(16);
  localparam logic [CFG_AW-3:0]         REG_CAPACITY = '0;
  localparam logic signed [VAL_W-1:0]   VALUE_MISS   = -32'sd1;

  typedef enum logic [1:0] {
    MODE_GET      = 2'd0,
    MODE_PUT      = 2'd1,
    MODE_CONTAINS = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [RANK_W-1:0] rank;
  } entry_t;

endpackage

// ===== rtl/core/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// Entries live in one single-port-read, single-port-write memory; requests are
// served by a scan pass over all entries and, when state changes, a
// read-modify-write pass that rewrites the recency ranks.
// ----------------------------------------------------------------------------
// Sequence: accept, scan pass, decide, then an update pass for get hit and put,
//   then the result; get miss and contains skip the update pass.
// A new request is accepted only in idle, after the last result is issued;
//   each pass walks one entry per cycle through the single memory read port.
// Reset (synchronous, active low): all entries invalid, occupancy zero,
//   capacity 16; memory contents are not cleared.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*lrukv_pkg::KEY_W-1:0]       in_tdata,   // [31:0] key, [63:32] value
  input  logic [lrukv_pkg::MODE_W-1:0]        in_tuser,   // [1:0] mode
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lrukv_pkg::VAL_W-1:0]         out_tdata,  // [31:0] value_out
  output logic [0:0]                          out_tuser,  // [0] found
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [lrukv_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [lrukv_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [lrukv_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                                cfg_pready
);
  import lrukv_pkg::*;

  // entry memory
  entry_t             mem [ENTRIES];
  entry_t             rd_data_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [IDX_W-1:0]   mem_ra;
  entry_t             mem_wd;

  // control
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [CAP_W-1:0]   capacity_r;
  logic               out_vld_r, out_vld_nxt;

  // request
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;

  // scan results
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [RANK_W-1:0]  hit_rank_r, hit_rank_nxt;
  logic [VAL_W-1:0]   hit_val_r, hit_val_nxt;
  logic               vic_ok_r, vic_ok_nxt;
  logic [IDX_W-1:0]   vic_idx_r, vic_idx_nxt;
  logic [RANK_W-1:0]  vic_rank_r, vic_rank_nxt;
  logic               free_ok_r, free_ok_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;

  // update pass
  logic [IDX_W-1:0]   tgt_r, tgt_nxt;
  logic [RANK_W-1:0]  thr_r, thr_nxt;
  logic               ins_r, ins_nxt;
  entry_t             upd_data;

  // result
  logic               res_found_r, res_found_nxt;
  logic [VAL_W-1:0]   res_value_r, res_value_nxt;
  logic               out_found_r, out_found_nxt;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;

  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   eff_cap;
  logic               full;
  logic               cfg_wr;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_CAPACITY) ?
                      CFG_DW'(capacity_r) : '0;

  always_comb begin
    cap_ext = CMP_W'(capacity_r);
    if (capacity_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    full = (CMP_W'(occ_r) >= eff_cap);
  end

  // --------------------------------------------------------------------------
  // rewritten entry for the update pass
  // --------------------------------------------------------------------------
  always_comb begin
    upd_data = rd_data_r;
    if (rd_idx_r == tgt_r) begin
      upd_data.rank = '0;
      if (ins_r) begin
        upd_data.key   = key_r;
        upd_data.value = val_r;
      end else if (mode_r == MODE_PUT) begin
        upd_data.value = val_r;
      end
    end else if (valid_r[rd_idx_r] && (ins_r || (rd_data_r.rank < thr_r))) begin
      upd_data.rank = rd_data_r.rank + RANK_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    occ_nxt       = occ_r;
    out_vld_nxt   = out_vld_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    hit_val_nxt   = hit_val_r;
    vic_ok_nxt    = vic_ok_r;
    vic_idx_nxt   = vic_idx_r;
    vic_rank_nxt  = vic_rank_r;
    free_ok_nxt   = free_ok_r;
    free_idx_nxt  = free_idx_r;
    tgt_nxt       = tgt_r;
    thr_nxt       = thr_r;
    ins_nxt       = ins_r;
    res_found_nxt = res_found_r;
    res_value_nxt = res_value_r;
    out_found_nxt = out_found_r;
    out_value_nxt = out_value_r;

    in_tready     = 1'b0;
    mem_ra        = cnt_r[IDX_W-1:0];
    rd_idx_nxt    = cnt_r[IDX_W-1:0];
    rd_vld_nxt    = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = rd_idx_r;
    mem_wd        = upd_data;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mode_nxt    = in_tuser;
          key_nxt     = in_tdata[KEY_W-1:0];
          val_nxt     = in_tdata[2*KEY_W-1:KEY_W];
          hit_nxt     = 1'b0;
          vic_ok_nxt  = 1'b0;
          free_ok_nxt = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        if (cnt_r < CNT_W'(ENTRIES)) begin
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (valid_r[rd_idx_r]) begin
            if (!hit_r && (rd_data_r.key == key_r)) begin
              hit_nxt      = 1'b1;
              hit_idx_nxt  = rd_idx_r;
              hit_rank_nxt = rd_data_r.rank;
              hit_val_nxt  = rd_data_r.value;
            end
            // oldest entry: strictly greater keeps the lowest index on ties
            if (!vic_ok_r || (rd_data_r.rank > vic_rank_r)) begin
              vic_ok_nxt   = 1'b1;
              vic_idx_nxt  = rd_idx_r;
              vic_rank_nxt = rd_data_r.rank;
            end
          end else if (!free_ok_r) begin
            free_ok_nxt  = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (rd_idx_r == IDX_W'(ENTRIES - 1)) begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        res_found_nxt = hit_r;
        res_value_nxt = '0;
        cnt_nxt       = '0;
        state_nxt     = S_DONE;
        if (mode_r == MODE_GET) begin
          if (hit_r) begin
            res_value_nxt = hit_val_r;
            tgt_nxt       = hit_idx_r;
            thr_nxt       = hit_rank_r;
            ins_nxt       = 1'b0;
            state_nxt     = S_UPD;
          end else begin
            res_value_nxt = VALUE_MISS;
          end
        end else if (mode_r == MODE_PUT) begin
          if (hit_r) begin
            tgt_nxt   = hit_idx_r;
            thr_nxt   = hit_rank_r;
            ins_nxt   = 1'b0;
            state_nxt = S_UPD;
          end else if (full && vic_ok_r) begin
            // evict and refill the same slot: valid and occupancy unchanged
            tgt_nxt   = vic_idx_r;
            ins_nxt   = 1'b1;
            state_nxt = S_UPD;
          end else if (free_ok_r) begin
            tgt_nxt             = free_idx_r;
            ins_nxt             = 1'b1;
            valid_nxt[free_idx_r] = 1'b1;
            occ_nxt             = occ_r + CNT_W'(1);
            state_nxt           = S_UPD;
          end
        end
      end

      S_UPD: begin
        // entry i is written in the cycle after its read, while i+1 is read,
        // so a read never meets a pending write to the same entry
        if (cnt_r < CNT_W'(ENTRIES)) begin
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          mem_we = 1'b1;
          if (rd_idx_r == IDX_W'(ENTRIES - 1)) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt   = 1'b1;
          out_found_nxt = res_found_r;
          out_value_nxt = res_value_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      valid_r    <= '0;
      occ_r      <= '0;
      capacity_r <= CAP_RESET;
      out_vld_r  <= 1'b0;
      hit_r      <= 1'b0;
      vic_ok_r   <= 1'b0;
      free_ok_r  <= 1'b0;
      ins_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      valid_r    <= valid_nxt;
      occ_r      <= occ_nxt;
      out_vld_r  <= out_vld_nxt;
      hit_r      <= hit_nxt;
      vic_ok_r   <= vic_ok_nxt;
      free_ok_r  <= free_ok_nxt;
      ins_r      <= ins_nxt;
      if (cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_CAPACITY)) begin
        capacity_r <= cfg_pwdata[CAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    mode_r      <= mode_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    hit_val_r   <= hit_val_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_rank_r  <= vic_rank_nxt;
    free_idx_r  <= free_idx_nxt;
    tgt_r       <= tgt_nxt;
    thr_r       <= thr_nxt;
    res_found_r <= res_found_nxt;
    res_value_r <= res_value_nxt;
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_found_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(valid_r) == int'(occ_r)))
    else $error("occupancy count disagrees with valid bits");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_SCAN))
    else $error("accepted request did not start a scan");

  a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_wa == $past(mem_ra)))
    else $error("update write does not match the entry read before it");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the completion state");

endmodule
